// ===== hw/rtl/esp_pkg.sv =====
package esp_pkg;

	// file offset counter width, also the width of data_offset
	localparam int OFFSET_BITS = 24;
	localparam int HDR_BITS    = 32;
	localparam int LEFT_BITS   = 17;

	localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;
	localparam logic [7:0]             MARK_BYTE = 8'hFF;
	localparam logic [15:0]            MARK_WORD = 16'hFFFF;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_TOO_SHORT = 3'd1,
		ST_BAD_MAGIC = 3'd2,
		ST_TRUNC_HDR = 3'd3,
		ST_BAD_RANGE = 3'd4,
		ST_TRUNC_SEG = 3'd5,
		ST_TOO_LONG  = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		PH_BOUNDARY   = 3'b001,
		PH_AFTER_MARK = 3'b010,
		PH_DATA       = 3'b100
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic                   segment_found;
		logic [15:0]            seg_start;
		logic [15:0]            seg_end;
		logic [OFFSET_BITS-1:0] data_offset;
		logic                   stream_done;
		status_t                status;
	} result_t;

endpackage

// ===== hw/rtl/esp_in_stage.sv =====
module esp_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  esp_pkg::in_item_t in_item,
	input  logic              out_free,
	output logic              advance,
	output esp_pkg::in_item_t item_s1
);
	import esp_pkg::*;

	logic valid_s1;

	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== hw/rtl/esp_parser.sv =====
module esp_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  esp_pkg::in_item_t item_s1,
	output logic              res_valid,
	output esp_pkg::result_t  res
);
	import esp_pkg::*;

	phase_t                 phase_q, phase_d;
	logic [1:0]             hcount_q, hcount_d;
	logic [HDR_BITS-1:0]    hbytes_q, hbytes_d;
	logic [LEFT_BITS-1:0]   left_q, left_d;
	logic [OFFSET_BITS-1:0] pos_q, pos_d;
	logic [OFFSET_BITS-1:0] segoff_q, segoff_d;
	status_t                err_q, err_d;

	logic [HDR_BITS-1:0]    hb_new;
	logic [15:0]            hstart, hend;
	logic [1:0]             hc_inc;
	logic                   seg;
	status_t                status;

	always_comb begin
		phase_d  = phase_q;
		hcount_d = hcount_q;
		hbytes_d = hbytes_q;
		left_d   = left_q;
		segoff_d = segoff_q;
		err_d    = err_q;
		seg      = 1'b0;
		status   = ST_OK;
		hb_new   = hbytes_q;
		hc_inc   = hcount_q + 2'd1;
		case (hcount_q)
			2'd0:    hb_new[7:0]   = hbytes_q[7:0]   | item_s1.data_byte;
			2'd1:    hb_new[15:8]  = hbytes_q[15:8]  | item_s1.data_byte;
			2'd2:    hb_new[23:16] = hbytes_q[23:16] | item_s1.data_byte;
			default: hb_new[31:24] = hbytes_q[31:24] | item_s1.data_byte;
		endcase
		hstart = hb_new[15:0];
		hend   = hb_new[31:16];

		// errors seen by this byte before any parsing
		if (pos_q == POS_MAX && err_d == ST_OK) begin
			err_d = ST_TOO_LONG;
		end
		if (pos_q < OFFSET_BITS'(2) && item_s1.data_byte != MARK_BYTE && err_d == ST_OK) begin
			err_d = ST_BAD_MAGIC;
		end

		if (err_d == ST_OK) begin
			if (phase_q == PH_DATA) begin
				left_d = left_q - LEFT_BITS'(1);
				if (left_d == '0) begin
					seg      = 1'b1;
					phase_d  = PH_BOUNDARY;
					hcount_d = 2'd0;
					hbytes_d = '0;
				end
			end else begin
				hbytes_d = hb_new;
				if (hcount_q == 2'd3) begin
					hcount_d = 2'd0;
					if (hend < hstart) begin
						err_d = ST_BAD_RANGE;
					end else begin
						left_d   = {1'b0, hend} - {1'b0, hstart} + LEFT_BITS'(1);
						segoff_d = pos_q + OFFSET_BITS'(1);
						phase_d  = PH_DATA;
					end
				end else begin
					hcount_d = hc_inc;
					// optional marker at a segment boundary
					if (phase_q == PH_BOUNDARY && hc_inc == 2'd2 && hb_new == HDR_BITS'(MARK_WORD)) begin
						hcount_d = 2'd0;
						hbytes_d = '0;
						phase_d  = PH_AFTER_MARK;
					end
				end
			end
		end

		pos_d = (pos_q == POS_MAX) ? pos_q : pos_q + OFFSET_BITS'(1);

		if (item_s1.last_byte) begin
			if (pos_q < OFFSET_BITS'(3)) begin
				status = ST_TOO_SHORT;
			end else if (err_d != ST_OK) begin
				status = err_d;
			end else if (phase_d == PH_DATA) begin
				status = ST_TRUNC_SEG;
			end else if (hcount_d != 2'd0) begin
				status = ST_TRUNC_HDR;
			end else begin
				status = ST_OK;
			end
		end

		res_valid         = seg || item_s1.last_byte;
		res.segment_found = seg;
		res.seg_start     = seg ? hbytes_q[15:0] : 16'd0;
		res.seg_end       = seg ? hbytes_q[31:16] : 16'd0;
		res.data_offset   = seg ? segoff_q : '0;
		res.stream_done   = item_s1.last_byte;
		res.status        = status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_BOUNDARY;
			hcount_q <= 2'd0;
			hbytes_q <= '0;
			left_q   <= '0;
			pos_q    <= '0;
			segoff_q <= '0;
			err_q    <= ST_OK;
		end else if (advance) begin
			if (item_s1.last_byte) begin
				// end of file, back to the reset state for the next one
				phase_q  <= PH_BOUNDARY;
				hcount_q <= 2'd0;
				hbytes_q <= '0;
				left_q   <= '0;
				pos_q    <= '0;
				segoff_q <= '0;
				err_q    <= ST_OK;
			end else begin
				phase_q  <= phase_d;
				hcount_q <= hcount_d;
				hbytes_q <= hbytes_d;
				left_q   <= left_d;
				pos_q    <= pos_d;
				segoff_q <= segoff_d;
				err_q    <= err_d;
			end
		end
	end

endmodule

// ===== hw/rtl/esp_out_stage.sv =====
module esp_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic             res_valid,
	input  esp_pkg::result_t res,
	output logic             out_free,
	output logic             out_valid,
	input  logic             out_ready,
	output esp_pkg::result_t res_s2
);
	import esp_pkg::*;

	logic valid_s2;

	assign out_free  = !valid_s2 || out_ready;
	assign out_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res_valid;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_s2 <= res;
		end
	end

endmodule

// ===== hw/rtl/executable_segment_parser_core.sv =====
// executable segment parser core
// input channel (s_*): one file byte per word in s_tdata[7:0], s_tlast on the
// final byte of the file. output channel (m_*): one result word whenever a
// segment's last data byte arrives or the file ends.
// m_tuser flags a completed segment, m_tlast marks the result for the final
// byte, which carries the status code in m_tdata[58:56].
// a byte is first captured in an input register, then parsed and written to
// the result register once that register is free; m_tvalid rises when the
// result register takes a result word.
// throughput is one byte per cycle unless a stalled result word blocks the
// result register; the parse step between the two registers is a single pass per byte.
// when the receiver stalls, the result register holds its word and the
// input register still takes one more byte; s_tready drops only once both
// are full.
// arst_n clears both valid flags and all parser state; the parser also
// returns to its reset state after the final byte of each file.
module executable_segment_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // seg_start, seg_end, data_offset, status, zero pad
	output logic        m_tuser,   // segment_found
	output logic        m_tlast    // stream_done
);
	import esp_pkg::*;

	in_item_t in_item, item_s1;
	result_t  res, res_s2;
	logic     advance, out_free, res_valid;

	assign in_item.data_byte = s_tdata;
	assign in_item.last_byte = s_tlast;

	// input register
	esp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.out_free (out_free),
		.advance  (advance),
		.item_s1  (item_s1)
	);

	// parser state and per-byte decision
	esp_parser u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.item_s1   (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register
	esp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.res_valid (res_valid),
		.res       (res),
		.out_free  (out_free),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.res_s2    (res_s2)
	);

	// pack result word, highest field first
	assign m_tdata = {5'd0, res_s2.status, res_s2.data_offset, res_s2.seg_end, res_s2.seg_start};
	assign m_tuser = res_s2.segment_found;
	assign m_tlast = res_s2.stream_done;

endmodule

// ===== hw/rtl/esp_checker.sv =====
module esp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);
	import esp_pkg::*;

	// a stalled result word stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("result word changed while stalled");

	// a word that is not a segment must be the end of the file
	a_word_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast && m_tdata[55:0] == 56'd0)
		else $error("result word with neither segment nor end of file");

	// status only on the final word
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[58:56] == ST_OK)
		else $error("status set on a word that is not the last");

	// a completed segment never has its end below its start
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[31:16] >= m_tdata[15:0])
		else $error("segment reported with end below start");

endmodule

bind executable_segment_parser_core esp_checker u_esp_checker (.*);

// ===== tb/sv/esp_report_checker.sv =====
`timescale 1ns / 1ps

// watches both channels, keeps its own parse of the byte stream and checks
// every result word against the oldest predicted report
module esp_report_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic        s_tlast,   // last_byte
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,   // seg_start, seg_end, data_offset, status, zero pad
	input  logic        m_tuser,   // segment_found
	input  logic        m_tlast,   // stream_done
	output int          fail_count,
	output int          outstanding,
	output int          reports_seen
);
	import esp_pkg::*;

	// parser copy
	phase_t                 cur_phase;
	logic [1:0]             hdr_cnt;
	logic [HDR_BITS-1:0]    hdr_word;
	logic [LEFT_BITS-1:0]   left_cnt;
	logic [OFFSET_BITS-1:0] file_pos;
	logic [OFFSET_BITS-1:0] seg_off;
	status_t                err_code;

	result_t parse_reports_q[$];

	task automatic clear_parser();
		cur_phase = PH_BOUNDARY;
		hdr_cnt   = '0;
		hdr_word  = '0;
		left_cnt  = '0;
		file_pos  = '0;
		seg_off   = '0;
		err_code  = ST_OK;
	endtask

	task automatic note_error(input status_t code);
		if (err_code == ST_OK) begin
			err_code = code;
		end
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t: %s wrong, got %0h, expected %0h", $time, what, got, want);
		fail_count++;
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic last);
		logic [OFFSET_BITS-1:0] here;
		logic [15:0]            lo;
		logic [15:0]            hi;
		result_t                r;
		here = file_pos;
		r = '0;
		if (here == POS_MAX) begin
			note_error(ST_TOO_LONG);
		end
		if (here < 2 && b != MARK_BYTE) begin
			note_error(ST_BAD_MAGIC);
		end
		if (err_code == ST_OK) begin
			if (cur_phase == PH_DATA) begin
				left_cnt = left_cnt - LEFT_BITS'(1);
				if (left_cnt == '0) begin
					r.segment_found = 1'b1;
					r.seg_start     = hdr_word[15:0];
					r.seg_end       = hdr_word[31:16];
					r.data_offset   = seg_off;
					cur_phase       = PH_BOUNDARY;
					hdr_cnt         = '0;
					hdr_word        = '0;
				end
			end else begin
				hdr_word = hdr_word | (32'(b) << (8 * hdr_cnt));
				if (hdr_cnt == 2'd3) begin
					lo      = hdr_word[15:0];
					hi      = hdr_word[31:16];
					hdr_cnt = '0;
					if (hi < lo) begin
						note_error(ST_BAD_RANGE);
					end else begin
						left_cnt  = {1'b0, hi} - {1'b0, lo} + LEFT_BITS'(1);
						seg_off   = here + OFFSET_BITS'(1);
						cur_phase = PH_DATA;
					end
				end else begin
					hdr_cnt = hdr_cnt + 2'd1;
					// a marker is only skipped right at a segment boundary
					if (cur_phase == PH_BOUNDARY && hdr_cnt == 2'd2 &&
					    hdr_word == {16'h0000, MARK_WORD}) begin
						hdr_cnt   = '0;
						hdr_word  = '0;
						cur_phase = PH_AFTER_MARK;
					end
				end
			end
		end
		if (file_pos != POS_MAX) begin
			file_pos = file_pos + OFFSET_BITS'(1);
		end
		if (last) begin
			r.stream_done = 1'b1;
			if (here < 3) begin
				r.status = ST_TOO_SHORT;
			end else if (err_code != ST_OK) begin
				r.status = err_code;
			end else if (cur_phase == PH_DATA) begin
				r.status = ST_TRUNC_SEG;
			end else if (hdr_cnt != 2'd0) begin
				r.status = ST_TRUNC_HDR;
			end else begin
				r.status = ST_OK;
			end
		end
		if (r.segment_found || r.stream_done) begin
			parse_reports_q.insert(parse_reports_q.size(), r);
		end
		if (last) begin
			clear_parser();
		end
	endtask

	task automatic check_word();
		result_t want;
		if (parse_reports_q.size() == 0) begin
			report("unexpected result word", m_tdata[31:0], '0);
			return;
		end
		want = parse_reports_q.pop_front();
		reports_seen++;
		if (m_tuser !== want.segment_found) begin
			report("segment_found", 32'(m_tuser), 32'(want.segment_found));
		end
		if (m_tdata[15:0] !== want.seg_start) begin
			report("seg_start", 32'(m_tdata[15:0]), 32'(want.seg_start));
		end
		if (m_tdata[31:16] !== want.seg_end) begin
			report("seg_end", 32'(m_tdata[31:16]), 32'(want.seg_end));
		end
		if (m_tdata[55:32] !== want.data_offset) begin
			report("data_offset", 32'(m_tdata[55:32]), 32'(want.data_offset));
		end
		if (m_tlast !== want.stream_done) begin
			report("stream_done", 32'(m_tlast), 32'(want.stream_done));
		end
		if (m_tdata[58:56] !== want.status) begin
			report("status", 32'(m_tdata[58:56]), 32'(want.status));
		end
		if (m_tdata[63:59] !== '0) begin
			report("pad bits", 32'(m_tdata[63:59]), '0);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parser();
			parse_reports_q.delete();
		end else begin
			if (s_tvalid && s_tready) begin
				parse_byte(s_tdata, s_tlast);
			end
			if (m_tvalid && m_tready) begin
				check_word();
			end
		end
		outstanding = parse_reports_q.size();
	end

endmodule

// ===== tb/sv/tb_executable_segment_parser_core.sv =====
`timescale 1ns / 1ps

module tb_executable_segment_parser_core;
	import esp_pkg::*;

	localparam int SEND_BYTES   = 750;     // random part stops after this many bytes
	localparam int CYCLE_LIMIT  = 600000;  // far above the slowest correct run
	localparam int DRAIN_CYCLES = 16;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;  // data_byte
	logic        s_tlast  = 1'b0;  // last_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;  // seg_start, seg_end, data_offset, status, zero pad
	logic        m_tuser;  // segment_found
	logic        m_tlast;  // stream_done

	int fail_count;
	int outstanding;
	int reports_seen;
	int cycle_cnt  = 0;
	int bytes_sent = 0;
	int files_sent = 0;
	bit tx_burst   = 1'b0;  // sender runs without gaps while set

	logic [7:0] file_q[$];  // bytes of the file being sent

	always #6 clk = ~clk;

	executable_segment_parser_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	esp_report_checker i_checker (.*);

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("tb_executable_segment_parser_core: done, errors");
			$finish;
		end
	end

	// receiver: random stall before each result word, with gap-free stretches
	initial begin
		int  gap;
		bit  rx_burst;
		rx_burst = 1'b0;
		wait (arst_n);
		forever begin
			if ($urandom_range(0, 15) == 0) begin
				rx_burst = !rx_burst;
			end
			gap = rx_burst ? 0 : $urandom_range(0, 19);
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	// one byte word, with a random gap ahead of it unless in a burst
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	task automatic send_file();
		for (int i = 0; i < file_q.size(); i++) begin
			send_byte(file_q[i], i == file_q.size() - 1);
		end
		files_sent++;
	endtask

	// hold the sender until every predicted report has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		do @(negedge clk); while (outstanding != 0);
		@(posedge clk);
	endtask

	// append one byte to the file being built
	task automatic put_byte(input logic [7:0] b);
		file_q.insert(file_q.size(), b);
	endtask

	// random file: mostly well-formed segment chains with random content,
	// some with a bad range, a broken magic or cut short, the rest noise
	task automatic build_random_file();
		int          kind;
		int          nseg;
		int          len;
		int          cut;
		logic [15:0] lo;
		logic [15:0] hi;
		file_q.delete();
		kind = $urandom_range(0, 99);
		if (kind < 12) begin
			// too short (under 4 bytes) or plain noise
			len = (kind < 6) ? $urandom_range(1, 3) : $urandom_range(4, 12);
			for (int i = 0; i < len; i++) begin
				put_byte(($urandom_range(0, 2) == 0) ? MARK_BYTE : 8'($urandom));
			end
		end else begin
			put_byte(MARK_BYTE);
			put_byte(MARK_BYTE);
			nseg = $urandom_range(0, 3);
			for (int s = 0; s < nseg; s++) begin
				// optional marker between segments
				if (s != 0 && $urandom_range(0, 1) == 1) begin
					put_byte(MARK_BYTE);
					put_byte(MARK_BYTE);
				end
				len = $urandom_range(1, 6);
				case ($urandom_range(0, 9))
					0: lo = 16'h0000;
					1: lo = 16'hFFFF;
					default: lo = 16'($urandom);
				endcase
				if (int'(lo) > 65536 - len) begin
					lo = 16'(65536 - len);
				end
				hi = lo + 16'(len - 1);
				// end below start
				if ($urandom_range(0, 11) == 0) begin
					lo = 16'($urandom_range(1, 65535));
					hi = 16'($urandom_range(0, int'(lo) - 1));
				end
				put_byte(lo[7:0]);
				put_byte(lo[15:8]);
				put_byte(hi[7:0]);
				put_byte(hi[15:8]);
				for (int i = 0; i < len; i++) begin
					put_byte(($urandom_range(0, 4) == 0) ? MARK_BYTE : 8'($urandom));
				end
			end
			// trailing marker with nothing after it
			if ($urandom_range(0, 7) == 0) begin
				put_byte(MARK_BYTE);
				put_byte(MARK_BYTE);
			end
			if (kind < 22) begin
				file_q[$urandom_range(0, 1)] = 8'($urandom_range(0, 254));
			end else if (kind < 45) begin
				cut = $urandom_range(1, file_q.size());
				while (file_q.size() > cut) begin
					void'(file_q.pop_back());
				end
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed files
		// single byte: too short
		file_q = {MARK_BYTE};
		send_file();
		// bad magic inside three bytes still reads as too short
		file_q = {8'h00, MARK_BYTE, 8'h12};
		send_file();
		// second magic byte wrong
		file_q = {MARK_BYTE, 8'h7F, 8'h00, 8'h00};
		send_file();
		// second FFFF right after a marker is a header, FFFF..FFFF, one byte,
		// segment and end of file in the same word
		file_q = {MARK_BYTE, MARK_BYTE, MARK_BYTE, MARK_BYTE, MARK_BYTE, MARK_BYTE, 8'h5A};
		send_file();
		// end below start
		file_q = {MARK_BYTE, MARK_BYTE, 8'h10, 8'h00, 8'h0F, 8'h00};
		send_file();
		// two data bytes announced, one delivered
		file_q = {MARK_BYTE, MARK_BYTE, 8'h00, 8'h00, 8'h01, 8'h00, 8'hAA};
		send_file();
		wait_drained();

		// random files, now and then with the sender held until all reports are in
		while (bytes_sent < SEND_BYTES) begin
			tx_burst = ($urandom_range(0, 4) == 0);
			build_random_file();
			send_file();
			if ($urandom_range(0, 7) == 0) begin
				wait_drained();
			end
		end
		tx_burst = 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d files, %0d bytes, checked %0d result words", files_sent,
		         bytes_sent, reports_seen);
		$display("covered short and bad-magic files, bad ranges, truncation, markers, stalls");
		if (fail_count == 0) begin
			$display("tb_executable_segment_parser_core: done, clean");
		end else begin
			$display("tb_executable_segment_parser_core: done, errors");
		end
		$finish;
	end

endmodule
